/* hdl/stlp_pkg.sv */
// Package for the time-line parser: character classes, result word,
// parser phases and the weekday/month name lookups. No dependencies.
package stlp_pkg;

  localparam logic [7:0] CHR_PLUS  = 8'h2B;
  localparam logic [7:0] CHR_QUOTE = 8'h22;
  localparam logic [7:0] CHR_COMMA = 8'h2C;
  localparam logic [7:0] CHR_MINUS = 8'h2D;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;

  localparam int         NUM_TF     = 4;
  localparam logic [2:0] YEAR_FIELD = 3'd4;

  localparam logic [23:0] DAY_NAMES [7] = '{"Mon", "Tue", "Wed", "Thu", "Fri", "Sat", "Sun"};
  localparam logic [23:0] MON_NAMES [12] = '{"Jan", "Feb", "Mar", "Apr", "May", "Jun",
                                             "Jul", "Aug", "Sep", "Oct", "Nov", "Dec"};

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       is_plus;
    logic       is_quote;
    logic       is_comma;
    logic       is_minus;
    logic       is_digit;
  } cls_t;

  typedef struct packed {
    logic [2:0]  weekday;
    logic [3:0]  month_code;
    logic [7:0]  day_of_month;
    logic [7:0]  hour_value;
    logic [7:0]  minute_value;
    logic [7:0]  second_value;
    logic [15:0] year_value;
  } rslt_t;

  typedef enum logic [3:0] {
    PH_PREFIX,
    PH_SKIP,
    PH_DAY,
    PH_DAY_SEP,
    PH_MON,
    PH_MON_SEP,
    PH_Q1,
    PH_C1,
    PH_Q2,
    PH_SIGN,
    PH_DIGITS,
    PH_TRAIL,
    PH_SEP,
    PH_DONE
  } phase_t;

  function automatic logic [2:0] day_lookup(input logic [23:0] nm);
    logic [2:0] code;
    code = '0;
    for (int i = 0; i < 7; i++) begin
      if (nm == DAY_NAMES[i]) code = 3'(i + 1);
    end
    return code;
  endfunction

  function automatic logic [3:0] mon_lookup(input logic [23:0] nm);
    logic [3:0] code;
    code = '0;
    for (int i = 0; i < 12; i++) begin
      if (nm == MON_NAMES[i]) code = 4'(i + 1);
    end
    return code;
  endfunction

  function automatic logic [15:0] signed_val(input logic [15:0] acc, input logic neg);
    return neg ? 16'(16'd0 - acc) : acc;
  endfunction

endpackage

/* hdl/stlp_fifo.sv */
// Small register queue with push/full and pop/empty handshakes.
// Generic width and depth; no package dependencies.
module stlp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wp_r, rp_r, wp_nxt, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             wr_en, rd_en;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign wr_en   = push && !full;
  assign rd_en   = pop && !empty;
  assign rd_data = mem_r[rp_r];

  assign wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : AW'(wp_r + AW'(1));
  assign rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : AW'(rp_r + AW'(1));

  always_comb begin
    case ({wr_en, rd_en})
      2'b10:   cnt_nxt = CW'(cnt_r + CW'(1));
      2'b01:   cnt_nxt = CW'(cnt_r - CW'(1));
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_nxt;
      if (rd_en) rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

endmodule

/* hdl/stlp_front.sv */
// Front end: classifies each accepted character into a tagged word.
// Depends on stlp_pkg.
module stlp_front (
  input  logic          push,
  input  logic [7:0]    char_in,
  input  logic          line_end,
  output logic          wr,
  output stlp_pkg::cls_t word
);

  import stlp_pkg::*;

  assign wr = push;

  always_comb begin
    word.ch       = char_in;
    word.last     = line_end;
    word.is_plus  = (char_in == CHR_PLUS);
    word.is_quote = (char_in == CHR_QUOTE);
    word.is_comma = (char_in == CHR_COMMA);
    word.is_minus = (char_in == CHR_MINUS);
    word.is_digit = (char_in >= CHR_ZERO) && (char_in <= CHR_NINE);
  end

endmodule

/* hdl/stlp_back.sv */
// Back end: parser state machine, name matching and field accumulation.
// Consumes one classified word per cycle while the result queue is not full; depends on stlp_pkg.
module stlp_back #(
  parameter int PREFIX_LEN = 13
) (
  input  logic           clk,
  input  logic           rst_n,
  input  stlp_pkg::cls_t word,
  input  logic           word_valid,
  output logic           word_pop,
  input  logic           res_full,
  output logic           res_push,
  output stlp_pkg::rslt_t res
);

  import stlp_pkg::*;

  localparam logic [3:0] CNT_SKIP = 4'(PREFIX_LEN - 1);

  phase_t      phase_r, phase_nxt, eff;
  logic [3:0]  cnt_r, cnt_nxt, name_cnt;
  logic [15:0] name_r, name_nxt;
  logic [2:0]  day_r, day_nxt;
  logic [3:0]  mon_r, mon_nxt;
  logic [15:0] acc_r, acc_nxt, acc10;
  logic        neg_r, neg_nxt;
  logic [2:0]  fidx_r, fidx_nxt;
  logic [7:0]  tf_r [NUM_TF];
  logic [7:0]  tf_nxt [NUM_TF];
  logic        commit_en;
  logic [15:0] commit_val;
  logic        take;

  assign take     = word_valid && !res_full;
  assign word_pop = take;
  assign res_push = take && word.last;
  assign name_cnt = (phase_r == PH_PREFIX) ? 4'd0 : cnt_r;
  assign acc10    = 16'({acc_r[12:0], 3'b000} + {acc_r[14:0], 1'b0} + {12'd0, word.ch[3:0]});

  function automatic logic consumes(input phase_t p, input cls_t w);
    logic c;
    unique case (p)
      PH_PREFIX: c = w.is_plus;
      PH_Q1:     c = w.is_quote;
      PH_C1:     c = w.is_comma;
      PH_Q2:     c = w.is_quote;
      PH_SIGN:   c = w.is_minus;
      PH_DIGITS: c = w.is_digit;
      PH_TRAIL:  c = w.is_comma;
      default:   c = 1'b1;
    endcase
    return c;
  endfunction

  function automatic phase_t fall(input phase_t p, input logic [2:0] fidx);
    phase_t n;
    unique case (p)
      PH_PREFIX: n = PH_DAY;
      PH_Q1:     n = PH_C1;
      PH_C1:     n = PH_Q2;
      PH_Q2:     n = PH_SIGN;
      PH_SIGN:   n = PH_DIGITS;
      PH_DIGITS: n = PH_TRAIL;
      PH_TRAIL:  n = (fidx >= YEAR_FIELD) ? PH_DONE : PH_SEP;
      default:   n = p;
    endcase
    return n;
  endfunction

  // find the phase that consumes this character
  always_comb begin : eff_decode
    phase_t p;
    logic   found;
    p     = phase_r;
    found = 1'b0;
    eff   = phase_r;
    for (int i = 0; i < 7; i++) begin
      if (!found) begin
        if (consumes(p, word)) begin
          found = 1'b1;
          eff   = p;
        end else begin
          p = fall(p, fidx_r);
        end
      end
    end
  end

  always_comb begin : next_state
    unique case (eff)
      PH_PREFIX:  phase_nxt = (PREFIX_LEN > 1) ? PH_SKIP : PH_DAY;
      PH_SKIP:    phase_nxt = (4'(cnt_r - 4'd1) == 4'd0) ? PH_DAY : PH_SKIP;
      PH_DAY:     phase_nxt = (name_cnt >= 4'd2) ? PH_DAY_SEP : PH_DAY;
      PH_DAY_SEP: phase_nxt = PH_MON;
      PH_MON:     phase_nxt = (cnt_r >= 4'd2) ? PH_MON_SEP : PH_MON;
      PH_MON_SEP: phase_nxt = PH_Q1;
      PH_Q1:      phase_nxt = PH_C1;
      PH_C1:      phase_nxt = PH_Q2;
      PH_Q2:      phase_nxt = PH_SIGN;
      PH_SIGN:    phase_nxt = PH_DIGITS;
      PH_DIGITS:  phase_nxt = PH_DIGITS;
      PH_TRAIL:   phase_nxt = (fidx_r >= YEAR_FIELD) ? PH_DONE : PH_SEP;
      PH_SEP:     phase_nxt = PH_Q1;
      default:    phase_nxt = PH_DONE;
    endcase
  end

  always_comb begin : datapath
    cnt_nxt    = cnt_r;
    name_nxt   = name_r;
    day_nxt    = day_r;
    mon_nxt    = mon_r;
    acc_nxt    = acc_r;
    neg_nxt    = neg_r;
    fidx_nxt   = fidx_r;
    tf_nxt     = tf_r;
    commit_en  = 1'b0;
    commit_val = '0;
    unique case (eff)
      PH_PREFIX: cnt_nxt = (PREFIX_LEN > 1) ? CNT_SKIP : 4'd0;
      PH_SKIP:   cnt_nxt = 4'(cnt_r - 4'd1);
      PH_DAY: begin
        if (name_cnt == 4'd0) begin
          name_nxt = {word.ch, 8'h00};
          cnt_nxt  = 4'd1;
          day_nxt  = '0;
        end else if (name_cnt == 4'd1) begin
          name_nxt = name_r | {8'h00, word.ch};
          cnt_nxt  = 4'd2;
          day_nxt  = '0;
        end else begin
          cnt_nxt = 4'd3;
          day_nxt = day_lookup({name_r, word.ch});
        end
      end
      PH_DAY_SEP: cnt_nxt = 4'd0;
      PH_MON: begin
        if (cnt_r == 4'd0) begin
          name_nxt = {word.ch, 8'h00};
          cnt_nxt  = 4'd1;
          mon_nxt  = '0;
        end else if (cnt_r == 4'd1) begin
          name_nxt = name_r | {8'h00, word.ch};
          cnt_nxt  = 4'd2;
          mon_nxt  = '0;
        end else begin
          cnt_nxt = 4'd3;
          mon_nxt = mon_lookup({name_r, word.ch});
        end
      end
      PH_MON_SEP: begin
        fidx_nxt = '0;
        acc_nxt  = '0;
        neg_nxt  = 1'b0;
      end
      PH_SIGN: begin
        neg_nxt    = 1'b1;
        commit_en  = 1'b1;
        commit_val = signed_val(acc_r, 1'b1);
      end
      PH_DIGITS: begin
        acc_nxt    = acc10;
        commit_en  = 1'b1;
        commit_val = signed_val(acc10, neg_r);
      end
      PH_SEP: begin
        fidx_nxt = 3'(fidx_r + 3'd1);
        acc_nxt  = '0;
        neg_nxt  = 1'b0;
      end
      default: ;
    endcase
    if (commit_en && (fidx_r < YEAR_FIELD)) tf_nxt[fidx_r[1:0]] = commit_val[7:0];
  end

  always_comb begin : result
    res.weekday      = day_nxt;
    res.month_code   = mon_nxt;
    res.day_of_month = tf_nxt[0];
    res.hour_value   = tf_nxt[1];
    res.minute_value = tf_nxt[2];
    res.second_value = tf_nxt[3];
    res.year_value   = (fidx_nxt == YEAR_FIELD) ? signed_val(acc_nxt, neg_nxt) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (take && word.last)) begin
      phase_r <= PH_PREFIX;
      cnt_r   <= '0;
      name_r  <= '0;
      day_r   <= '0;
      mon_r   <= '0;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      fidx_r  <= '0;
      for (int i = 0; i < NUM_TF; i++) tf_r[i] <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      name_r  <= name_nxt;
      day_r   <= day_nxt;
      mon_r   <= mon_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      fidx_r  <= fidx_nxt;
      tf_r    <= tf_nxt;
    end
  end

  a_fidx_range: assert property (@(posedge clk) disable iff (!rst_n)
    fidx_r <= YEAR_FIELD)
    else $error("field index past year");

  a_line_restart: assert property (@(posedge clk) disable iff (!rst_n)
    take && word.last |=> phase_r == PH_PREFIX && fidx_r == 3'd0 && acc_r == 16'd0)
    else $error("parser not restarted after line end");

  a_skip_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_SKIP |-> cnt_r != 4'd0)
    else $error("prefix skip with zero count");

  a_name_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DAY || phase_r == PH_MON) |-> cnt_r <= 4'd2)
    else $error("name count overrun");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    word_valid && res_full |=> $stable(phase_r) && $stable(acc_r))
    else $error("state moved while output queue full");

endmodule

/* hdl/sntp_time_line_parser.sv */
// Time-line parser: one character per cycle in while the input queue is not full, one result word per line out.
// A line-end character passes through the input queue and the back end; its result is registered in the output queue.
// Throughput: 1 character per cycle while neither queue is full, set by the parser step in the back end.
// Two-entry queues sit between front and back end and before the result ports.
// Reset (rst_n low, synchronous) empties both queues and returns the parser to prefix check.
// Depends on stlp_pkg, stlp_front, stlp_fifo and stlp_back.
module sntp_time_line_parser #(
  parameter int PREFIX_LEN = 13
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_char_in,
  input  logic        in_line_end,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_weekday,
  output logic [3:0]  out_month_code,
  output logic [7:0]  out_day_of_month,
  output logic [7:0]  out_hour_value,
  output logic [7:0]  out_minute_value,
  output logic [7:0]  out_second_value,
  output logic [15:0] out_year_value
);

  import stlp_pkg::*;

  cls_t  fr_word, bk_word;
  rslt_t bk_res, out_word;
  logic  fr_wr, a_empty, bk_pop, b_full, bk_push;

  stlp_front u_front (
    .push     (push),
    .char_in  (in_char_in),
    .line_end (in_line_end),
    .wr       (fr_wr),
    .word     (fr_word)
  );

  stlp_fifo #(
    .WIDTH ($bits(cls_t)),
    .DEPTH (2)
  ) u_in_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (fr_wr),
    .wr_data (fr_word),
    .full    (full),
    .pop     (bk_pop),
    .rd_data (bk_word),
    .empty   (a_empty)
  );

  stlp_back #(
    .PREFIX_LEN (PREFIX_LEN)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .word       (bk_word),
    .word_valid (!a_empty),
    .word_pop   (bk_pop),
    .res_full   (b_full),
    .res_push   (bk_push),
    .res        (bk_res)
  );

  stlp_fifo #(
    .WIDTH ($bits(rslt_t)),
    .DEPTH (2)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (bk_push),
    .wr_data (bk_res),
    .full    (b_full),
    .pop     (pop),
    .rd_data (out_word),
    .empty   (empty)
  );

  assign out_weekday      = out_word.weekday;
  assign out_month_code   = out_word.month_code;
  assign out_day_of_month = out_word.day_of_month;
  assign out_hour_value   = out_word.hour_value;
  assign out_minute_value = out_word.minute_value;
  assign out_second_value = out_word.second_value;
  assign out_year_value   = out_word.year_value;

endmodule
